### rtl/core/ddpq_pkg.sv
// ----------------------------------------------------------------------------
// ddpq_pkg
// shared types and codes for the dual drop-oldest priority queue
// ----------------------------------------------------------------------------
package ddpq_pkg;

  localparam int OP_W      = 2;
  localparam int WORD_W    = 32;
  localparam int LINK_W    = 2;
  localparam int STAT_IX_W = 3;
  localparam int STATUS_W  = 3;
  localparam int FCOUNT_W  = 3;
  localparam int ACOUNT_W  = 4;
  localparam int NUM_CNT   = 7;

  localparam logic [OP_W-1:0] OP_ENQ_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ_AUX   = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVICE   = 2'd2;

  localparam logic [LINK_W-1:0] LINK_OK   = 2'd0;
  localparam logic [LINK_W-1:0] LINK_BUSY = 2'd1;

  localparam logic [STATUS_W-1:0] ST_ENQ_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ENQ_DROP = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SENT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd5;

  localparam logic [STAT_IX_W-1:0] CNT_FRAME_ENQ = 3'd0;
  localparam logic [STAT_IX_W-1:0] CNT_FRAME_OVF = 3'd1;
  localparam logic [STAT_IX_W-1:0] CNT_AUX_ENQ   = 3'd2;
  localparam logic [STAT_IX_W-1:0] CNT_AUX_OVF   = 3'd3;
  localparam logic [STAT_IX_W-1:0] CNT_OK        = 3'd4;
  localparam logic [STAT_IX_W-1:0] CNT_BUSY      = 3'd5;
  localparam logic [STAT_IX_W-1:0] CNT_ERROR     = 3'd6;
  localparam logic [STAT_IX_W-1:0] STAT_LAST     = 3'd7;

  localparam logic [WORD_W-1:0] AUX_MASK_RESET = 32'd1;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [WORD_W-1:0]    payload;
    logic [LINK_W-1:0]    link_status;
    logic [STAT_IX_W-1:0] stat_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_code;
    logic                tx_valid;
    logic                tx_from_aux;
    logic [WORD_W-1:0]   tx_payload;
    logic [FCOUNT_W-1:0] frame_count;
    logic [ACOUNT_W-1:0] aux_count;
    logic [WORD_W-1:0]   stat_value;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_flags_t;

endpackage

### rtl/core/ddpq_ring.sv
// ----------------------------------------------------------------------------
// ddpq_ring
// register ring queue that drops its oldest entry when pushed while full
// ----------------------------------------------------------------------------
module ddpq_ring #(
  parameter int DEPTH  = 4,
  parameter int WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ddpq_pkg::ring_ctrl_t         ctrl,
  input  logic [WIDTH-1:0]             wdata,
  output logic [WIDTH-1:0]             head_data,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic [$clog2(DEPTH+1)-1:0]   fill_next,
  output ddpq_pkg::ring_flags_t        flags
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [IW-1:0]    head;
  logic [IW-1:0]    head_next;
  logic [IW-1:0]    tail;
  logic [IW-1:0]    tail_next;
  logic [IW-1:0]    head_inc;
  logic [IW-1:0]    tail_inc;

  assign flags.full  = (fill == FULL_FILL);
  assign flags.empty = (fill == '0);
  assign head_data   = store[head];
  assign head_inc    = (head == LAST_IX) ? '0 : head + 1'b1;
  assign tail_inc    = (tail == LAST_IX) ? '0 : tail + 1'b1;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (ctrl.push) begin
      tail_next = tail_inc;
      if (flags.full) begin
        head_next = head_inc;
      end else begin
        fill_next = fill + 1'b1;
      end
    end else if (ctrl.pop) begin
      head_next = head_inc;
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[tail] <= wdata;
    end
  end

endmodule

### rtl/core/dual_drop_oldest_priority_queue_top.sv
// ----------------------------------------------------------------------------
// dual_drop_oldest_priority_queue_top
// frame and aux drop-oldest queues with strict-priority link service
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A beat is taken in every cycle while the
// output is not backed up: the queues, counters and the result are all worked
// out in the cycle the beat is taken; the result is registered into the
// output register, or the skid register while the output is stalled. A
// two-entry output buffer (output register plus skid register) lets one more
// beat in while a result waits; stall reaches the input once the skid is full.
// No clearing pass follows reset; queue contents are only read once written.
module dual_drop_oldest_priority_queue_top #(
  parameter int FRAME_DEPTH   = 4,
  parameter int AUX_DEPTH     = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ddpq_pkg::out_item_t out_data
);

  localparam int WW  = ddpq_pkg::WORD_W;
  localparam int SW  = (PAYLOAD_WIDTH < WW) ? PAYLOAD_WIDTH : WW;
  localparam int FFW = $clog2(FRAME_DEPTH + 1);
  localparam int AFW = $clog2(AUX_DEPTH + 1);
  localparam int FCW = ddpq_pkg::FCOUNT_W;
  localparam int ACW = ddpq_pkg::ACOUNT_W;
  localparam int LW  = ddpq_pkg::LINK_W;

  logic [WW-1:0]         aux_overflow_mask;
  logic [WW-1:0]         counters      [ddpq_pkg::NUM_CNT];
  logic [WW-1:0]         counters_next [ddpq_pkg::NUM_CNT];
  logic [LW-1:0]         last_status;
  logic [LW-1:0]         last_status_next;

  logic                  accept;
  logic                  frame_push;
  logic                  aux_push;
  logic                  service;
  logic                  use_aux;
  logic                  link_ok;
  logic                  link_busy;
  logic [SW-1:0]         aux_wdata;
  logic [SW-1:0]         tx_word;

  ddpq_pkg::ring_ctrl_t  f_ctrl;
  ddpq_pkg::ring_ctrl_t  a_ctrl;
  ddpq_pkg::ring_flags_t f_flags;
  ddpq_pkg::ring_flags_t a_flags;
  logic [SW-1:0]         f_head;
  logic [SW-1:0]         a_head;
  logic [FFW-1:0]        f_fill;
  logic [FFW-1:0]        f_fill_next;
  logic [AFW-1:0]        a_fill;
  logic [AFW-1:0]        a_fill_next;

  ddpq_pkg::out_item_t   result;
  ddpq_pkg::out_item_t   skid;
  logic                  skid_valid;

  assign in_stall   = skid_valid;
  assign accept     = in_valid && !in_stall;
  assign frame_push = accept && (in_data.op == ddpq_pkg::OP_ENQ_FRAME);
  assign aux_push   = accept && (in_data.op == ddpq_pkg::OP_ENQ_AUX);
  assign service    = accept && (in_data.op == ddpq_pkg::OP_SERVICE)
                      && !(f_flags.empty && a_flags.empty);
  assign use_aux    = f_flags.empty;
  assign link_ok    = (in_data.link_status == ddpq_pkg::LINK_OK);
  assign link_busy  = (in_data.link_status == ddpq_pkg::LINK_BUSY);

  assign f_ctrl.push = frame_push;
  assign f_ctrl.pop  = service && link_ok && !use_aux;
  assign a_ctrl.push = aux_push;
  assign a_ctrl.pop  = service && link_ok && use_aux;

  assign aux_wdata = SW'(in_data.payload)
                     | (a_flags.full ? SW'(aux_overflow_mask) : '0);
  assign tx_word   = use_aux ? a_head : f_head;

  ddpq_ring #(
    .DEPTH (FRAME_DEPTH),
    .WIDTH (SW)
  ) u_frame_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (f_ctrl),
    .wdata     (SW'(in_data.payload)),
    .head_data (f_head),
    .fill      (f_fill),
    .fill_next (f_fill_next),
    .flags     (f_flags)
  );

  ddpq_ring #(
    .DEPTH (AUX_DEPTH),
    .WIDTH (SW)
  ) u_aux_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (a_ctrl),
    .wdata     (aux_wdata),
    .head_data (a_head),
    .fill      (a_fill),
    .fill_next (a_fill_next),
    .flags     (a_flags)
  );

  // statistics update
  always_comb begin
    counters_next    = counters;
    last_status_next = last_status;
    if (frame_push) begin
      counters_next[ddpq_pkg::CNT_FRAME_ENQ] = counters[ddpq_pkg::CNT_FRAME_ENQ] + 1'b1;
      if (f_flags.full) begin
        counters_next[ddpq_pkg::CNT_FRAME_OVF] = counters[ddpq_pkg::CNT_FRAME_OVF] + 1'b1;
      end
    end
    if (aux_push) begin
      counters_next[ddpq_pkg::CNT_AUX_ENQ] = counters[ddpq_pkg::CNT_AUX_ENQ] + 1'b1;
      if (a_flags.full) begin
        counters_next[ddpq_pkg::CNT_AUX_OVF] = counters[ddpq_pkg::CNT_AUX_OVF] + 1'b1;
      end
    end
    if (service) begin
      last_status_next = in_data.link_status;
      priority if (link_ok) begin
        counters_next[ddpq_pkg::CNT_OK] = counters[ddpq_pkg::CNT_OK] + 1'b1;
      end else if (link_busy) begin
        counters_next[ddpq_pkg::CNT_BUSY] = counters[ddpq_pkg::CNT_BUSY] + 1'b1;
      end else begin
        counters_next[ddpq_pkg::CNT_ERROR] = counters[ddpq_pkg::CNT_ERROR] + 1'b1;
      end
    end
  end

  // result beat
  always_comb begin
    result             = '0;
    result.status_code = ddpq_pkg::ST_IDLE;
    if (frame_push) begin
      result.status_code = f_flags.full ? ddpq_pkg::ST_ENQ_DROP : ddpq_pkg::ST_ENQ_OK;
    end else if (aux_push) begin
      result.status_code = a_flags.full ? ddpq_pkg::ST_ENQ_DROP : ddpq_pkg::ST_ENQ_OK;
    end else if (service) begin
      result.tx_valid    = 1'b1;
      result.tx_from_aux = use_aux;
      result.tx_payload  = WW'(tx_word);
      priority if (link_ok) begin
        result.status_code = ddpq_pkg::ST_SENT;
      end else if (link_busy) begin
        result.status_code = ddpq_pkg::ST_BUSY;
      end else begin
        result.status_code = ddpq_pkg::ST_ERROR;
      end
    end
    result.frame_count = FCW'(f_fill_next);
    result.aux_count   = ACW'(a_fill_next);
    if (in_data.stat_index == ddpq_pkg::STAT_LAST) begin
      result.stat_value = WW'(last_status_next);
    end else begin
      result.stat_value = counters_next[in_data.stat_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aux_overflow_mask <= ddpq_pkg::AUX_MASK_RESET;
      counters          <= '{default: '0};
      last_status       <= '0;
    end else begin
      if (cfg_wr_en) begin
        aux_overflow_mask <= cfg_wr_data;
      end
      counters    <= counters_next;
      last_status <= last_status_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && out_stall) begin
        skid <= result;
      end else begin
        out_data <= result;
      end
    end else if ((!out_valid || !out_stall) && skid_valid) begin
      out_data <= skid;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  a_tx_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tx_valid) |->
      (out_data.status_code == ddpq_pkg::ST_SENT ||
       out_data.status_code == ddpq_pkg::ST_BUSY ||
       out_data.status_code == ddpq_pkg::ST_ERROR))
    else $error("offered entry with a non-service status");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    (f_fill <= FFW'(FRAME_DEPTH)) && (a_fill <= AFW'(AUX_DEPTH)))
    else $error("queue fill beyond depth");

  a_frame_enq_count : assert property (@(posedge clk) disable iff (rst)
    frame_push |=> (counters[ddpq_pkg::CNT_FRAME_ENQ]
                    == $past(counters[ddpq_pkg::CNT_FRAME_ENQ]) + 1'b1))
    else $error("frame enqueue not counted");

endmodule

### bench/ddpq_result_checker.sv
// ----------------------------------------------------------------------------
// ddpq_result_checker
// watches both channels of the dual drop-oldest queue, keeps its own copy of
// the frame and aux rings, counters and overflow mask, works out the result of
// every accepted input beat and compares it field by field with the output
// ----------------------------------------------------------------------------
module ddpq_result_checker
  import ddpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int          mismatches,
  output int          awaited,
  output int          compared
);

  localparam int FRAME_SLOTS = 4;
  localparam int AUX_SLOTS   = 8;

  logic [WORD_W-1:0] frame_words [FRAME_SLOTS];
  logic [WORD_W-1:0] aux_words [AUX_SLOTS];
  int                frame_rd, frame_wr, frame_used;
  int                aux_rd, aux_wr, aux_used;
  logic [WORD_W-1:0] event_tally [NUM_CNT];
  logic [LINK_W-1:0] last_link;
  logic [WORD_W-1:0] overflow_mask;
  out_item_t         results_due [$];

  task automatic clear_state();
    frame_rd      = 0;
    frame_wr      = 0;
    frame_used    = 0;
    aux_rd        = 0;
    aux_wr        = 0;
    aux_used      = 0;
    last_link     = LINK_OK;
    overflow_mask = AUX_MASK_RESET;
    for (int i = 0; i < NUM_CNT; i++) event_tally[i] = '0;
    results_due.delete();
  endtask

  function automatic out_item_t queue_step(in_item_t beat);
    out_item_t         res;
    logic [WORD_W-1:0] word;
    logic              take_aux;
    res             = '0;
    res.status_code = ST_IDLE;
    word            = beat.payload;
    case (beat.op)
      OP_ENQ_FRAME: begin
        res.status_code = ST_ENQ_OK;
        if (frame_used == FRAME_SLOTS) begin
          frame_rd = (frame_rd + 1) % FRAME_SLOTS;
          frame_used--;
          event_tally[CNT_FRAME_OVF]++;
          res.status_code = ST_ENQ_DROP;
        end
        frame_words[frame_wr] = word;
        frame_wr = (frame_wr + 1) % FRAME_SLOTS;
        frame_used++;
        event_tally[CNT_FRAME_ENQ]++;
      end
      OP_ENQ_AUX: begin
        res.status_code = ST_ENQ_OK;
        if (aux_used == AUX_SLOTS) begin
          word = word | overflow_mask;
          aux_rd = (aux_rd + 1) % AUX_SLOTS;
          aux_used--;
          event_tally[CNT_AUX_OVF]++;
          res.status_code = ST_ENQ_DROP;
        end
        aux_words[aux_wr] = word;
        aux_wr = (aux_wr + 1) % AUX_SLOTS;
        aux_used++;
        event_tally[CNT_AUX_ENQ]++;
      end
      OP_SERVICE: begin
        if (frame_used != 0 || aux_used != 0) begin
          take_aux        = (frame_used == 0);
          res.tx_valid    = 1'b1;
          res.tx_from_aux = take_aux;
          res.tx_payload  = take_aux ? aux_words[aux_rd] : frame_words[frame_rd];
          last_link       = beat.link_status;
          if (beat.link_status == LINK_OK) begin
            event_tally[CNT_OK]++;
            res.status_code = ST_SENT;
            if (take_aux) begin
              aux_rd = (aux_rd + 1) % AUX_SLOTS;
              aux_used--;
            end else begin
              frame_rd = (frame_rd + 1) % FRAME_SLOTS;
              frame_used--;
            end
          end else if (beat.link_status == LINK_BUSY) begin
            event_tally[CNT_BUSY]++;
            res.status_code = ST_BUSY;
          end else begin
            // any other link answer counts as an error, entry kept
            event_tally[CNT_ERROR]++;
            res.status_code = ST_ERROR;
          end
        end
      end
      default: ;
    endcase
    res.frame_count = frame_used[FCOUNT_W-1:0];
    res.aux_count   = aux_used[ACOUNT_W-1:0];
    if (beat.stat_index == STAT_LAST) res.stat_value = {{(WORD_W-LINK_W){1'b0}}, last_link};
    else res.stat_value = event_tally[beat.stat_index];
    return res;
  endfunction

  task automatic check_field(string label, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t seen;
    out_item_t due;
    if (rst) begin
      clear_state();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (cfg_wr_en) overflow_mask = cfg_wr_data;
      if (in_valid && !in_stall) results_due.push_back(queue_step(in_data));
      if (out_valid && !out_stall) begin
        seen = out_data;
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing awaited, expected none got %h", $time, seen);
        end else begin
          due = results_due.pop_front();
          compared++;
          check_field("status_code", WORD_W'(due.status_code), WORD_W'(seen.status_code));
          check_field("tx_valid", WORD_W'(due.tx_valid), WORD_W'(seen.tx_valid));
          check_field("tx_from_aux", WORD_W'(due.tx_from_aux), WORD_W'(seen.tx_from_aux));
          check_field("tx_payload", due.tx_payload, seen.tx_payload);
          check_field("frame_count", WORD_W'(due.frame_count), WORD_W'(seen.frame_count));
          check_field("aux_count", WORD_W'(due.aux_count), WORD_W'(seen.aux_count));
          check_field("stat_value", due.stat_value, seen.stat_value);
        end
      end
    end
    awaited = results_due.size();
  end

endmodule

### bench/dual_drop_oldest_priority_queue_top_test.sv
// ----------------------------------------------------------------------------
// dual_drop_oldest_priority_queue_top_test
// drives enqueue and service beats into the dual drop-oldest queue under
// bursty input and a varying output stall pattern, across several aux
// overflow masks; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module dual_drop_oldest_priority_queue_top_test;
  import ddpq_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [LINK_W-1:0] LINK_ERROR  = 2'd2;
  localparam logic [LINK_W-1:0] LINK_UNDEF  = 2'd3;
  localparam int                IDLE_LIMIT  = 2000;
  localparam int                HOLD_CYCLES = 80;
  localparam int                PHASE_BEATS = 205;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;

  int mismatches, awaited, compared;
  int beats_sent = 0;
  int quiet      = 0;
  bit hold_now   = 1'b0;
  bit hold_done  = 1'b0;

  always #2 clk = ~clk;

  dual_drop_oldest_priority_queue_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  ddpq_result_checker result_watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .awaited     (awaited),
    .compared    (compared)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver stall pattern, with one long hold-off when asked
  initial begin : link_side
    int mode;
    int seg;
    forever begin
      mode = $urandom_range(3);
      seg  = $urandom_range(20, 150);
      for (int k = 0; k < seg; k++) begin
        @(negedge clk);
        if (hold_now && !hold_done) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 25);
          2: out_stall <= ($urandom_range(99) < 70);
          default: out_stall <= ((k % 5) < 2);
        endcase
      end
    end
  end

  task automatic put_beat(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                          input logic [LINK_W-1:0] link, input logic [STAT_IX_W-1:0] pick);
    in_item_t beat;
    beat.op          = op;
    beat.payload     = word;
    beat.link_status = link;
    beat.stat_index  = pick;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic write_mask(input logic [31:0] mask);
    pause_input(1);
    wait (awaited == 0 && !out_valid);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_beat(input int enq_pct);
    int                  r;
    int                  q;
    logic [OP_W-1:0]     op;
    logic [LINK_W-1:0]   link;
    logic [WORD_W-1:0]   word;
    r = $urandom_range(99);
    if (r < 5) op = OP_UNUSED;
    else if (r < 5 + enq_pct) op = $urandom_range(1) ? OP_ENQ_AUX : OP_ENQ_FRAME;
    else op = OP_SERVICE;
    q = $urandom_range(99);
    if (q < 55) link = LINK_OK;
    else if (q < 70) link = LINK_BUSY;
    else if (q < 88) link = LINK_ERROR;
    else link = LINK_UNDEF;
    q = $urandom_range(9);
    if (q == 0) word = '0;
    else if (q == 1) word = '1;
    else word = $urandom;
    put_beat(op, word, link, STAT_IX_W'($urandom_range(7)));
  endtask

  task automatic random_phase(input int beats, input int enq_pct);
    int burst;
    int done;
    done = 0;
    while (done < beats) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && done < beats; i++) begin
        random_beat(enq_pct);
        done++;
      end
      if ($urandom_range(9) == 0) pause_input($urandom_range(10, 20));
      else pause_input($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty service and the unused op
    put_beat(OP_SERVICE, 32'h0000_0000, LINK_OK, STAT_LAST);
    put_beat(OP_UNUSED, 32'hffff_ffff, LINK_UNDEF, CNT_FRAME_ENQ);
    // fill the frame queue, then push once more to drop the oldest
    put_beat(OP_ENQ_FRAME, 32'h0000_0000, LINK_OK, CNT_FRAME_ENQ);
    put_beat(OP_ENQ_FRAME, 32'hffff_ffff, LINK_OK, CNT_FRAME_OVF);
    put_beat(OP_ENQ_FRAME, 32'ha5a5_a5a5, LINK_OK, CNT_FRAME_ENQ);
    put_beat(OP_ENQ_FRAME, 32'h5a5a_5a5a, LINK_OK, CNT_FRAME_ENQ);
    put_beat(OP_ENQ_FRAME, 32'h1234_5678, LINK_OK, CNT_FRAME_OVF);
    // fill aux, then overflow it so the reset mask is ORed in
    put_beat(OP_ENQ_AUX, 32'h0000_0000, LINK_OK, CNT_AUX_ENQ);
    put_beat(OP_ENQ_AUX, 32'hffff_ffff, LINK_OK, CNT_AUX_ENQ);
    for (int i = 2; i < 8; i++) put_beat(OP_ENQ_AUX, 32'h100 + i, LINK_OK, CNT_AUX_ENQ);
    put_beat(OP_ENQ_AUX, 32'h0000_0000, LINK_OK, CNT_AUX_OVF);
    put_beat(OP_ENQ_AUX, 32'hffff_fffe, LINK_OK, CNT_AUX_OVF);
    // retry answers keep the frame head
    put_beat(OP_SERVICE, 32'h0, LINK_BUSY, CNT_BUSY);
    put_beat(OP_SERVICE, 32'h0, LINK_ERROR, CNT_ERROR);
    put_beat(OP_SERVICE, 32'h0, LINK_UNDEF, STAT_LAST);
    // drain frame, then the next service falls through to aux
    for (int i = 0; i < 4; i++) put_beat(OP_SERVICE, 32'h0, LINK_OK, CNT_OK);
    put_beat(OP_SERVICE, 32'h0, LINK_OK, CNT_AUX_ENQ);

    hold_now = 1'b1;
    random_phase(PHASE_BEATS, 45);
    write_mask(32'h0000_0000);
    random_phase(PHASE_BEATS, 60);
    write_mask(32'hffff_ffff);
    random_phase(PHASE_BEATS, 50);
    write_mask($urandom);
    random_phase(PHASE_BEATS, 35);

    pause_input(1);
    wait (awaited == 0);
    repeat (6) @(posedge clk);
    $display("covered %0d beats in and %0d results compared under four aux mask values",
             beats_sent, compared);
    $display("including overflow of both queues, link retries and one %0d cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0 && awaited == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ddpq_pkg.sv
rtl/core/ddpq_ring.sv
rtl/core/dual_drop_oldest_priority_queue_top.sv
bench/ddpq_result_checker.sv
bench/dual_drop_oldest_priority_queue_top_test.sv
